// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_CHECK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CHECK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

// ----- rtl/hed_pkg.sv -----
// ----------------------------------------------------------------------------
// hed_pkg
// Types, character codes and helpers for the HTML entity decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hed_pkg;

  typedef enum logic [2:0] {
    MODE_PLAIN   = 3'b001,
    MODE_AMP     = 3'b010,
    MODE_COLLECT = 3'b100
  } scan_mode_t;

  // result of closing an entity: zero, one or two code units
  typedef struct packed {
    logic [1:0]  n;
    logic [15:0] u0;
    logic [15:0] u1;
  } fin_t;

  localparam logic [15:0] CH_AMP   = 16'h0026;
  localparam logic [15:0] CH_HASH  = 16'h0023;
  localparam logic [15:0] CH_SEMI  = 16'h003B;
  localparam logic [15:0] CH_X     = 16'h0078;
  localparam logic [15:0] CH_PLUS  = 16'h002B;
  localparam logic [15:0] CH_MINUS = 16'h002D;
  localparam logic [15:0] CH_QUOTE = 16'h0022;
  localparam logic [15:0] CH_APOS  = 16'h0027;
  localparam logic [15:0] CH_LT    = 16'h003C;
  localparam logic [15:0] CH_GT    = 16'h003E;

  localparam int unsigned HEAD_N = 4;  // longest known name
  localparam logic [20:0] CODE_LIMIT = 21'h10FFFF;
  localparam logic [20:0] PLANE1     = 21'h010000;

  function automatic logic is_space(input logic [15:0] u);
    logic r;
    r = (u >= 16'h0009 && u <= 16'h000D) || u == 16'h0020 || u == 16'h0085 ||
        u == 16'h00A0 || u == 16'h1680 || (u >= 16'h2000 && u <= 16'h200A) ||
        u == 16'h2028 || u == 16'h2029 || u == 16'h202F || u == 16'h205F ||
        u == 16'h3000;
    return r;
  endfunction

endpackage

// ----- rtl/html_entity_decoder_top.sv -----
// ----------------------------------------------------------------------------
// html_entity_decoder_top
// Decodes HTML character entities in a stream of UTF-16 code units.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------
//  in      | in_valid/in_stall  | unit_in, text_last
//  out     | out_valid/out_stall| unit_out, has_unit, run_last, text_end
//
// One input unit per cycle is taken; its results (0 to 3) are decoded in the
// same cycle into a 3-entry result register and leave one per cycle.
// Input stalls while the result register holds results, unless the final one
// is being taken; after a unit with 2 or 3 results, input waits for the last.
// Reset (rst, synchronous) returns to plain text with no pending results.
// out_stall holds the current result; in_stall follows it combinationally.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module html_entity_decoder_top #(
  parameter int NAME_MAX = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] unit_in,
  input  logic        text_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] unit_out,
  output logic        has_unit,
  output logic        run_last,
  output logic        text_end
);
  import hed_pkg::*;

  localparam int CNT_W = $clog2(NAME_MAX + 1);

  // entity state
  scan_mode_t              scan_mode;
  logic                    numeric_entity;
  logic [CNT_W-1:0]        name_count;
  logic [HEAD_N-1:0][15:0] name_head;
  logic [20:0]             code_value;
  logic                    value_bad;

  // state after the unit itself, before end-of-text close
  scan_mode_t              mode1;
  logic                    num1;
  logic [CNT_W-1:0]        cnt1;
  logic [HEAD_N-1:0][15:0] head1;
  logic [20:0]             val1;
  logic                    bad1;

  logic                    do_fin1;
  logic                    do_fin2;
  logic                    plain_em;
  fin_t                    fin1;
  fin_t                    fin2;

  // result register
  logic [15:0]             rb_unit [3];
  logic                    rb_has;
  logic                    rb_last;
  logic [1:0]              rb_cnt;
  logic [1:0]              rd_idx;

  logic [15:0]             em_unit [3];
  logic [1:0]              em_cnt;
  logic                    em_bare;

  logic                    in_acc;
  logic                    pop;
  logic                    pop_final;

  function automatic fin_t close_entity(
    input logic                    num,
    input logic                    bad,
    input logic [20:0]             val,
    input logic [CNT_W-1:0]        cnt,
    input logic [HEAD_N-1:0][15:0] hd
  );
    fin_t        f;
    logic [20:0] c;
    logic [19:0] v;
    c = '0;
    if (num) begin
      c = bad ? 21'h0 : val;
    end else if (cnt == CNT_W'(4) && hd[0] == 16'h0071 && hd[1] == 16'h0075 &&
                 hd[2] == 16'h006F && hd[3] == 16'h0074) begin
      c = {5'h0, CH_QUOTE};
    end else if (cnt == CNT_W'(4) && hd[0] == 16'h0061 && hd[1] == 16'h0070 &&
                 hd[2] == 16'h006F && hd[3] == 16'h0073) begin
      c = {5'h0, CH_APOS};
    end else if (cnt == CNT_W'(2) && hd[0] == 16'h006C && hd[1] == 16'h0074) begin
      c = {5'h0, CH_LT};
    end else if (cnt == CNT_W'(2) && hd[0] == 16'h0067 && hd[1] == 16'h0074) begin
      c = {5'h0, CH_GT};
    end else if (cnt == CNT_W'(3) && hd[0] == 16'h0061 && hd[1] == 16'h006D &&
                 hd[2] == 16'h0070) begin
      c = {5'h0, CH_AMP};
    end
    v = 20'(c - PLANE1);
    f.n  = 2'd0;
    f.u0 = c[15:0];
    f.u1 = 16'hDC00 + {6'h0, v[9:0]};
    if (c != 21'h0 && c <= CODE_LIMIT) begin
      if (c[20:16] != 5'h0) begin
        f.n  = 2'd2;
        f.u0 = 16'hD800 + {6'h0, v[19:10]};
      end else begin
        f.n = 2'd1;
      end
    end
    return f;
  endfunction

  // --- per-unit step ---------------------------------------------------------
  always_comb begin
    logic        ent;
    logic        take_plain;
    logic        do_col;
    logic        hex;
    logic        dig_ok;
    logic [3:0]  d;
    logic [24:0] acc;
    ent        = 1'b0;
    take_plain = 1'b0;
    do_col     = 1'b0;
    do_fin1    = 1'b0;
    plain_em   = 1'b0;
    mode1      = scan_mode;
    num1       = numeric_entity;
    cnt1       = name_count;
    head1      = name_head;
    val1       = code_value;
    bad1       = value_bad;

    case (scan_mode)
      MODE_PLAIN: begin
        take_plain = 1'b1;
      end
      MODE_AMP: begin
        if (unit_in == CH_HASH) begin
          num1  = 1'b1;
          mode1 = MODE_COLLECT;
        end else begin
          ent = 1'b1;
        end
      end
      default: begin
        ent = 1'b1;
      end
    endcase

    if (ent) begin
      mode1 = MODE_COLLECT;
      if (name_count >= CNT_W'(NAME_MAX)) begin
        do_fin1    = 1'b1;
        take_plain = (unit_in != CH_SEMI);
      end else if (unit_in == CH_SEMI) begin
        do_fin1 = 1'b1;
      end else if (is_space(unit_in)) begin
        do_fin1    = 1'b1;
        take_plain = 1'b1;
      end else begin
        do_col = 1'b1;
      end
    end

    if (do_fin1) begin
      mode1 = MODE_PLAIN;
      num1  = 1'b0;
      cnt1  = '0;
      val1  = '0;
      bad1  = 1'b0;
    end

    if (take_plain) begin
      if (unit_in == CH_AMP) begin
        mode1 = MODE_AMP;
        num1  = 1'b0;
        cnt1  = '0;
        val1  = '0;
        bad1  = 1'b0;
      end else begin
        plain_em = 1'b1;
      end
    end

    // digit decode; hex is known from the first collected unit
    hex = (name_count == '0) ? (unit_in == CH_X) : (name_head[0] == CH_X);
    d      = unit_in[3:0];
    dig_ok = 1'b0;
    if (unit_in >= 16'h0030 && unit_in <= 16'h0039) begin
      dig_ok = 1'b1;
    end else if (hex && ((unit_in >= 16'h0061 && unit_in <= 16'h0066) ||
                         (unit_in >= 16'h0041 && unit_in <= 16'h0046))) begin
      dig_ok = 1'b1;
      d      = unit_in[3:0] + 4'd9;
    end
    if (hex) begin
      acc = {code_value, 4'h0} + 25'(d);
    end else begin
      acc = {1'b0, code_value, 3'h0} + {3'h0, code_value, 1'b0} + 25'(d);
    end

    if (do_col) begin
      cnt1 = name_count + CNT_W'(1);
      if (name_count < CNT_W'(HEAD_N)) begin
        head1[name_count[1:0]] = unit_in;
      end
      if (numeric_entity) begin
        if (hex && name_count == '0) begin
          // the 'x' prefix itself
        end else if (name_count == (hex ? CNT_W'(1) : CNT_W'(0)) &&
                     unit_in == CH_PLUS) begin
          // leading plus sign ignored
        end else if (name_count == (hex ? CNT_W'(1) : CNT_W'(0)) &&
                     unit_in == CH_MINUS) begin
          bad1 = 1'b1;
        end else if (!dig_ok) begin
          bad1 = 1'b1;
        end else if (!value_bad) begin
          if (acc > 25'(CODE_LIMIT)) begin
            bad1 = 1'b1;
          end else begin
            val1 = acc[20:0];
          end
        end
      end
    end
  end

  assign fin1    = close_entity(numeric_entity, value_bad, code_value, name_count, name_head);
  assign fin2    = close_entity(num1, bad1, val1, cnt1, head1);
  assign do_fin2 = text_last && (mode1 != MODE_PLAIN);

  // gather the results of this unit in order
  always_comb begin
    logic [1:0] k;
    k          = 2'd0;
    em_unit[0] = 16'h0;
    em_unit[1] = 16'h0;
    em_unit[2] = 16'h0;
    if (do_fin1 && fin1.n != 2'd0) begin
      em_unit[k] = fin1.u0;
      k          = k + 2'd1;
      if (fin1.n == 2'd2) begin
        em_unit[k] = fin1.u1;
        k          = k + 2'd1;
      end
    end
    if (plain_em) begin
      em_unit[k] = unit_in;
      k          = k + 2'd1;
    end
    if (do_fin2 && fin2.n != 2'd0) begin
      em_unit[k] = fin2.u0;
      k          = k + 2'd1;
      if (fin2.n == 2'd2) begin
        em_unit[k] = fin2.u1;
        k          = k + 2'd1;
      end
    end
    em_bare = (k == 2'd0) && text_last;
    em_cnt  = em_bare ? 2'd1 : k;
  end

  // --- handshakes ------------------------------------------------------------
  assign out_valid = (rb_cnt != 2'd0);
  assign unit_out  = rb_unit[rd_idx];
  assign has_unit  = rb_has;
  assign run_last  = (rd_idx == rb_cnt - 2'd1);
  assign text_end  = run_last && rb_last;

  assign pop       = out_valid && !out_stall;
  assign pop_final = pop && run_last;
  assign in_stall  = out_valid && !pop_final;
  assign in_acc    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode      <= MODE_PLAIN;
      numeric_entity <= 1'b0;
      name_count     <= '0;
      code_value     <= '0;
      value_bad      <= 1'b0;
      rb_cnt         <= 2'd0;
      rd_idx         <= 2'd0;
    end else begin
      if (in_acc) begin
        if (do_fin2) begin
          scan_mode      <= MODE_PLAIN;
          numeric_entity <= 1'b0;
          name_count     <= '0;
          code_value     <= '0;
          value_bad      <= 1'b0;
        end else begin
          scan_mode      <= mode1;
          numeric_entity <= num1;
          name_count     <= cnt1;
          code_value     <= val1;
          value_bad      <= bad1;
        end
      end
      if (in_acc && em_cnt != 2'd0) begin
        rb_cnt <= em_cnt;
        rd_idx <= 2'd0;
      end else if (pop_final) begin
        rb_cnt <= 2'd0;
        rd_idx <= 2'd0;
      end else if (pop) begin
        rd_idx <= rd_idx + 2'd1;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      name_head <= head1;
    end
    if (in_acc && em_cnt != 2'd0) begin
      rb_unit[0] <= em_unit[0];
      rb_unit[1] <= em_unit[1];
      rb_unit[2] <= em_unit[2];
      rb_has     <= !em_bare;
      rb_last    <= text_last;
    end
  end

  // --- checks ----------------------------------------------------------------
  `ASSERT_CHECK(a_rd_in_range, clk, rst, (rb_cnt != 2'd0) |-> (rd_idx < rb_cnt))
  `ASSERT_CHECK(a_bare_is_end, clk, rst,
                (out_valid && !has_unit) |-> (run_last && text_end && unit_out == 16'h0))
  `ASSERT_CHECK(a_text_closes, clk, rst,
                (in_valid && !in_stall && text_last) |=> (scan_mode == MODE_PLAIN))
  `ASSERT_NEVER(a_count_max, clk, rst, name_count > CNT_W'(NAME_MAX))
  `ASSERT_NEVER(a_value_range, clk, rst, !value_bad && code_value > CODE_LIMIT)

endmodule
